### hw/rtl/cap_touch_pad_detector_unit_defines.svh
// Assertion macros shared by the touch detector RTL.
`ifndef CAP_TOUCH_PAD_DETECTOR_UNIT_DEFINES_SVH
`define CAP_TOUCH_PAD_DETECTOR_UNIT_DEFINES_SVH

// Implication checked every clock edge outside reset.
`define CTPD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CTPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ctpd_pkg.sv
package ctpd_pkg;

    localparam int unsigned PAD_W = 4;
    localparam int unsigned NPADS = 16;

    typedef enum logic [1:0] {
        ACT_CALIB = 2'd0,
        ACT_SCAN  = 2'd1,
        ACT_FRAME = 2'd2,
        ACT_DRIFT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_TIMEOUT = 3'd0,
        REG_HYST    = 3'd1,
        REG_SAMPLES = 3'd2,
        REG_RATE    = 3'd3,
        REG_DRIFT   = 3'd4
    } cfg_index_t;

    // Start/done pair between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [7:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    // floor(bq * 5 / 4) >> 16, 17 bits
    function automatic logic [16:0] thr_of(input logic [31:0] bq);
        logic [34:0] p;
        p = {3'd0, bq} + {1'b0, bq, 2'b00};
        return p[34:18];
    endfunction

endpackage

### hw/rtl/ctpd_divider.sv
module ctpd_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctpd_pkg::div_req_t req,
    output ctpd_pkg::div_rsp_t rsp
);
    import ctpd_pkg::*;

    logic [23:0] quo_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [8:0]  trial;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[23]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd24;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                den_reg  <= req.divisor;
            end else if (busy_reg) begin
                if (!trial[8]) begin
                    rem_reg <= trial[7:0];
                    quo_reg <= {quo_reg[22:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[6:0], quo_reg[23]};
                    quo_reg <= {quo_reg[22:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[15:0];

endmodule

### hw/rtl/cap_touch_pad_detector_unit.sv
// Sequence: every item passes READ and DONE; a calibration sample that finishes the pad
//   also passes DIV (bit-serial divide), a scan sample that is not touched MUL and EMA
//   (16x32 EMA multiply), a calibrated drift check WALK (one pad per cycle through the
//   shared compare). Throughput: one item at a time, the next transfer taken once the
//   sequencer is idle. One result may wait in the result register during the next item.
// Reset: synchronous, active low; clears control, masks, counts and sums.
module cap_touch_pad_detector_unit #(
    parameter int unsigned PAD_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_pad,
    input  logic [15:0] s_charge_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_pad_echo,
    output logic        m_touched,
    output logic [15:0] m_pressed_mask,
    output logic [15:0] m_press_edges,
    output logic [15:0] m_release_edges,
    output logic        m_drifted,
    output logic        m_ready_res,
    output logic [15:0] m_pad_baseline,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ctpd_pkg::*;
`include "cap_touch_pad_detector_unit_defines.svh"

    localparam logic [15:0] ALL_PADS = 16'((17'd1 << PAD_COUNT) - 17'd1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_EMA   = 7'b0010000,
        ST_WALK  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] timeout_reg, hyst_reg, rate_reg, dlimit_reg;
    logic [7:0]  samples_reg;

    // per-pad storage
    logic [31:0] base_mem [NPADS];
    logic [16:0] thr_mem  [NPADS];
    logic [15:0] last_mem [NPADS];
    logic [23:0] sum_mem  [NPADS];
    logic [7:0]  cnt_mem  [NPADS];
    logic [15:0] done_bits_reg;
    logic [15:0] committed_reg, previous_reg, pending_reg;
    logic        calibrated_reg;

    // current item
    logic [1:0]  act_reg;
    logic [3:0]  pad_reg;
    logic [15:0] t_reg;
    logic [31:0] bq_reg;
    logic [16:0] thr_reg;
    logic [23:0] sum_reg;
    logic [7:0]  cs_reg;
    logic [32:0] diff_reg;
    logic        up_reg;
    logic [48:0] prod_reg;
    logic [4:0]  walk_reg;
    logic [15:0] worst_reg;

    // working result fields of the current item
    logic        o_touch_reg, o_drift_reg;
    logic [15:0] o_press_reg, o_rel_reg;
    logic [3:0]  o_pad_reg;

    // result register, held until the output transfer
    logic        out_valid_reg;
    logic [15:0] o_base_reg;
    logic [3:0]  res_pad_reg;
    logic        res_touch_reg, res_drift_reg, res_rdy_reg;
    logic [15:0] res_mask_reg, res_press_reg, res_rel_reg;
    logic        out_free;

    div_req_t div_req;
    div_rsp_t div_rsp;

    ctpd_divider u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    logic        pad_ok;
    logic [15:0] b_int;
    logic [15:0] dpos;
    logic        on_bit;
    logic        touch;
    logic [3:0]  widx;
    logic [15:0] wb, wl, wd;
    logic [31:0] new_bq;

    assign pad_ok = 5'(pad_reg) < 5'(PAD_COUNT);
    assign b_int  = bq_reg[31:16];
    assign dpos   = (t_reg > b_int) ? t_reg - b_int : 16'd0;
    assign on_bit = committed_reg[pad_reg];
    assign touch  = on_bit ? (dpos >= hyst_reg)
                           : ({1'b0, t_reg} >= thr_reg && t_reg < timeout_reg);
    assign widx   = walk_reg[3:0];
    assign wb     = base_mem[widx][31:16];
    assign wl     = last_mem[widx];
    assign wd     = (wl > wb) ? wl - wb : 16'd0;
    assign new_bq = up_reg ? bq_reg + prod_reg[47:16] : bq_reg - prod_reg[47:16];

    // result register can take a new result this cycle
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign div_req.start    = (state_reg == ST_READ) && act_reg == ACT_CALIB && pad_ok
                              && !calibrated_reg && !done_bits_reg[pad_reg]
                              && (cnt_mem[pad_reg] + 8'd1 >= cs_reg);
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = cs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 16'd1000;
            hyst_reg    <= 16'd10;
            samples_reg <= 8'd200;
            rate_reg    <= 16'd66;
            dlimit_reg  <= 16'd50;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_HYST:    hyst_reg    <= cfg_data;
                REG_SAMPLES: samples_reg <= cfg_data[7:0];
                REG_RATE:    rate_reg    <= cfg_data;
                REG_DRIFT:   dlimit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            done_bits_reg  <= '0;
            committed_reg  <= '0;
            previous_reg   <= '0;
            pending_reg    <= '0;
            calibrated_reg <= 1'b0;
            for (int i = 0; i < NPADS; i++) begin
                last_mem[i] <= '0;
                sum_mem[i]  <= '0;
                cnt_mem[i]  <= '0;
            end
        end else begin
            // load a finished result, or drop the one just transferred
            if (state_reg == ST_DONE && out_free) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    // take a transfer and latch the pad's stored values
                    if (s_valid && s_ready) begin
                        act_reg   <= s_action;
                        pad_reg   <= s_pad;
                        t_reg     <= s_charge_time;
                        bq_reg    <= base_mem[s_pad];
                        thr_reg   <= thr_mem[s_pad];
                        sum_reg   <= sum_mem[s_pad] + 24'(s_charge_time);
                        cs_reg    <= (samples_reg == 8'd0) ? 8'd1 : samples_reg;
                        o_pad_reg <= (s_action == ACT_CALIB || s_action == ACT_SCAN)
                                     ? s_pad : 4'd0;
                        o_touch_reg <= 1'b0;
                        o_drift_reg <= 1'b0;
                        o_press_reg <= '0;
                        o_rel_reg   <= '0;
                        walk_reg    <= '0;
                        worst_reg   <= '0;
                        state_reg   <= ST_READ;
                    end
                end
                ST_READ: begin
                    unique case (act_reg)
                        ACT_CALIB: begin
                            if (pad_ok && !calibrated_reg && !done_bits_reg[pad_reg]) begin
                                sum_mem[pad_reg] <= sum_reg;
                                cnt_mem[pad_reg] <= cnt_mem[pad_reg] + 8'd1;
                                state_reg <= div_req.start ? ST_DIV : ST_DONE;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                        ACT_SCAN: begin
                            if (pad_ok && calibrated_reg) begin
                                last_mem[pad_reg] <= t_reg;
                                o_touch_reg <= touch;
                                if (touch) begin
                                    pending_reg[pad_reg] <= 1'b1;
                                    state_reg <= ST_DONE;
                                end else begin
                                    pending_reg[pad_reg] <= 1'b0;
                                    up_reg   <= {t_reg, 16'd0} >= bq_reg;
                                    diff_reg <= ({t_reg, 16'd0} >= bq_reg)
                                                ? {1'b0, t_reg, 16'd0} - {1'b0, bq_reg}
                                                : {1'b0, bq_reg} - {1'b0, t_reg, 16'd0};
                                    state_reg <= ST_MUL;
                                end
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end
                        ACT_FRAME: begin
                            if (calibrated_reg) begin
                                previous_reg  <= committed_reg;
                                committed_reg <= pending_reg & ALL_PADS;
                                pending_reg   <= '0;
                                o_press_reg   <= pending_reg & ALL_PADS & ~committed_reg;
                                o_rel_reg     <= committed_reg & ~(pending_reg & ALL_PADS);
                            end
                            state_reg <= ST_DONE;
                        end
                        default: begin
                            state_reg <= calibrated_reg ? ST_WALK : ST_DONE;
                        end
                    endcase
                end
                ST_DIV: begin
                    // wait for the shared divider, then finish the pad
                    if (div_rsp.done) begin
                        base_mem[pad_reg] <= {div_rsp.quotient, 16'd0};
                        bq_reg            <= {div_rsp.quotient, 16'd0};
                        thr_mem[pad_reg]  <= thr_of({div_rsp.quotient, 16'd0});
                        last_mem[pad_reg] <= div_rsp.quotient;
                        done_bits_reg[pad_reg] <= 1'b1;
                        if (((done_bits_reg | (16'd1 << pad_reg)) & ALL_PADS) == ALL_PADS) begin
                            committed_reg  <= '0;
                            previous_reg   <= '0;
                            pending_reg    <= '0;
                            calibrated_reg <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= diff_reg[31:0] * {17'd0, rate_reg};
                    state_reg <= ST_EMA;
                end
                ST_EMA: begin
                    base_mem[pad_reg] <= new_bq;
                    bq_reg            <= new_bq;
                    thr_mem[pad_reg]  <= thr_of(new_bq);
                    state_reg <= ST_DONE;
                end
                ST_WALK: begin
                    // one pad per cycle through the compare
                    if (walk_reg == 5'(PAD_COUNT)) begin
                        if (worst_reg > dlimit_reg) begin
                            for (int i = 0; i < NPADS; i++) begin
                                sum_mem[i] <= '0;
                                cnt_mem[i] <= '0;
                            end
                            done_bits_reg  <= '0;
                            calibrated_reg <= 1'b0;
                            o_drift_reg    <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        if (!committed_reg[widx] && wd > worst_reg) worst_reg <= wd;
                        walk_reg <= walk_reg + 5'd1;
                    end
                end
                ST_DONE: begin
                    // hold here while the previous result still waits
                    if (out_free) begin
                        o_base_reg <= ((act_reg == ACT_CALIB || act_reg == ACT_SCAN) && pad_ok
                                       && done_bits_reg[pad_reg]) ? bq_reg[31:16] : 16'd0;
                        res_pad_reg   <= o_pad_reg;
                        res_touch_reg <= o_touch_reg;
                        res_mask_reg  <= committed_reg;
                        res_press_reg <= o_press_reg;
                        res_rel_reg   <= o_rel_reg;
                        res_drift_reg <= o_drift_reg;
                        res_rdy_reg   <= calibrated_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pad_echo      = res_pad_reg;
    assign m_touched       = res_touch_reg;
    assign m_pressed_mask  = res_mask_reg;
    assign m_press_edges   = res_press_reg;
    assign m_release_edges = res_rel_reg;
    assign m_drifted       = res_drift_reg;
    assign m_ready_res     = res_rdy_reg;
    assign m_pad_baseline  = o_base_reg;

    `CTPD_ASSERT_IMPL(a_busy_blocks, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "ready while busy")
    `CTPD_ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == ST_DONE && out_free, out_valid_reg, "no result after done")
    `CTPD_ASSERT_IMPL(a_div_only_calib, aclk, aresetn, div_req.start, act_reg == ACT_CALIB, "divide outside calibration")
    `CTPD_ASSERT_IMPL(a_cal_all_done, aclk, aresetn, calibrated_reg, (done_bits_reg & ALL_PADS) == ALL_PADS, "flag without all pads")

endmodule
